/* hw/rtl/case_folding_run_length_encoder_top_macros.svh */
// Assertion macros shared by the encoder RTL.
// Expects clk and arst_n in the scope of the including module.
`ifndef CASE_FOLDING_RUN_LENGTH_ENCODER_TOP_MACROS_SVH
`define CASE_FOLDING_RUN_LENGTH_ENCODER_TOP_MACROS_SVH

// Same-cycle implication.
`define CFRLE_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CFRLE_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/cfrle_pkg.sv */
// Shared types, constants and helper functions of the case-folding run-length encoder.
// No dependencies.
package cfrle_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PW = 2;
	localparam int QUEUE_CW = 3;

	// One finished run, plus an optional single trailing character flushed by
	// the end of the string.
	typedef struct packed {
		logic [7:0] run_char;
		logic       tail_valid;
		logic [7:0] tail_char;
		logic       done;
	} rec_t;

	typedef enum logic [1:0] {
		PH_DIGIT,
		PH_CHAR,
		PH_TAIL
	} phase_t;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_LOW_A = 8'h61;
	localparam logic [7:0] ASCII_LOW_Z = 8'h7a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	function automatic logic [7:0] fold_upper(logic [7:0] c);
		if (c >= ASCII_LOW_A && c <= ASCII_LOW_Z) begin
			return c - CASE_OFFSET;
		end
		return c;
	endfunction

	function automatic int unsigned pow10(int unsigned e);
		int unsigned p;
		p = 1;
		for (int unsigned i = 0; i < e; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	// Decimal digits needed for the all-ones value of a w-bit counter.
	function automatic int unsigned dec_digits(int unsigned w);
		int unsigned maxv;
		int unsigned n;
		maxv = (32'd1 << w) - 32'd1;
		n = 1;
		for (int unsigned i = 1; i < 10; i++) begin
			if (pow10(i) <= maxv) begin
				n = i + 1;
			end
		end
		return n;
	endfunction

endpackage

/* hw/rtl/cfrle_front.sv */
// Run tracker: accepts one byte per cycle unless the queue is full, folds case,
// and pushes finished runs. Depends on cfrle_pkg.
module cfrle_front #(
	parameter int CW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_char,
	input  logic              in_end,
	input  logic              q_full,
	output logic              in_ready,
	output logic              push,
	output cfrle_pkg::rec_t   push_rec,
	output logic [CW-1:0]     push_cnt
);
	import cfrle_pkg::*;

	localparam logic [CW-1:0] CNT_MAX = '1;
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	logic [7:0]    held_q;
	logic [CW-1:0] run_q;
	logic          holding_q;

	logic          acc;
	logic          same;
	logic [CW-1:0] run_inc;

	assign in_ready = !q_full;
	assign acc = in_valid && in_ready;
	assign same = holding_q && (fold_upper(in_char) == fold_upper(held_q));
	assign run_inc = (run_q != CNT_MAX) ? run_q + CNT_ONE : run_q;

	always_comb begin
		push = acc && (in_end || (holding_q && !same));
		push_rec.run_char = held_q;
		push_rec.tail_valid = 1'b0;
		push_rec.tail_char = in_char;
		push_rec.done = in_end;
		push_cnt = run_q;
		priority if (same) begin
			push_cnt = run_inc;
		end else if (holding_q) begin
			push_rec.tail_valid = in_end;
		end else begin
			push_rec.run_char = in_char;
			push_cnt = CNT_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			run_q <= '0;
			holding_q <= 1'b0;
		end else if (acc) begin
			priority if (in_end) begin
				held_q <= '0;
				run_q <= '0;
				holding_q <= 1'b0;
			end else if (same) begin
				run_q <= run_inc;
			end else begin
				held_q <= in_char;
				run_q <= CNT_ONE;
				holding_q <= 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/cfrle_queue.sv */
// Short run queue between the run tracker and the digit emitter.
// Depends on cfrle_pkg and the assertion macro header.
`include "case_folding_run_length_encoder_top_macros.svh"
module cfrle_queue #(
	parameter int CW = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cfrle_pkg::rec_t push_rec,
	input  logic [CW-1:0]   push_cnt,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output cfrle_pkg::rec_t head_rec,
	output logic [CW-1:0]   head_cnt
);
	import cfrle_pkg::*;

	rec_t                mem_q [QUEUE_DEPTH];
	logic [CW-1:0]       cnt_mem_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wr_ptr_q;
	logic [QUEUE_PW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	assign full = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head_rec = mem_q[rd_ptr_q];
	assign head_cnt = cnt_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
			cnt_mem_q[wr_ptr_q] <= push_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PW'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + QUEUE_CW'(1);
				2'b01: count_q <= count_q - QUEUE_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`CFRLE_ASSERT_IMP(a_no_pop_empty, pop, !empty, "queue popped while empty")
	`CFRLE_ASSERT_IMP(a_no_push_full, push, !full, "queue pushed while full")
	`CFRLE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= QUEUE_CW'(QUEUE_DEPTH), "queue count overrun")

endmodule

/* hw/rtl/cfrle_back.sv */
// Digit emitter: turns queued runs into output bytes, one decimal digit per cycle
// unless the output stalls. Depends on cfrle_pkg and the assertion macro header.
`include "case_folding_run_length_encoder_top_macros.svh"
module cfrle_back #(
	parameter int CW = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  cfrle_pkg::rec_t head_rec,
	input  logic [CW-1:0]   head_cnt,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_char,
	output logic            out_item,
	output logic            out_done
);
	import cfrle_pkg::*;

	localparam int D = int'(dec_digits(CW));
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int TW = CW + 4;

	logic [TW-1:0] step_tab [D][10];

	logic          cur_valid_q, cur_valid_d;
	phase_t        phase_q, phase_d;
	rec_t          rec_q, rec_d;
	logic          multi_q, multi_d;
	logic [CW-1:0] rem_q, rem_d;
	logic [PW-1:0] pidx_q, pidx_d;

	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_item_q;
	logic          out_done_q;

	logic          can_load;
	logic          emit;
	logic          fin;
	logic [7:0]    byte_val;
	logic [3:0]    digit;
	logic [CW-1:0] rem_next;
	logic [PW-1:0] start_idx;
	logic          load;

	// k * 10^i for every digit position
	always_comb begin
		for (int i = 0; i < D; i++) begin
			for (int k = 0; k < 10; k++) begin
				step_tab[i][k] = TW'(pow10(i) * k);
			end
		end
	end

	always_comb begin
		digit = '0;
		for (int k = 1; k < 10; k++) begin
			if ({4'b0, rem_q} >= step_tab[pidx_q][k]) begin
				digit = 4'(k);
			end
		end
		rem_next = CW'({4'b0, rem_q} - step_tab[pidx_q][digit]);
	end

	// highest nonzero digit position of the head count
	always_comb begin
		start_idx = '0;
		for (int i = 1; i < D; i++) begin
			if ({4'b0, head_cnt} >= step_tab[i][1]) begin
				start_idx = PW'(i);
			end
		end
	end

	assign can_load = !out_valid_q || out_ready;
	assign emit = cur_valid_q && can_load;

	always_comb begin
		cur_valid_d = cur_valid_q;
		phase_d = phase_q;
		rec_d = rec_q;
		multi_d = multi_q;
		rem_d = rem_q;
		pidx_d = pidx_q;
		pop = 1'b0;
		byte_val = rec_q.run_char;
		fin = 1'b0;

		unique case (phase_q)
			PH_DIGIT: begin
				byte_val = ASCII_ZERO + {4'b0, digit};
				fin = 1'b0;
			end
			PH_CHAR: begin
				byte_val = multi_q ? fold_upper(rec_q.run_char) : rec_q.run_char;
				fin = !rec_q.tail_valid;
			end
			PH_TAIL: begin
				byte_val = rec_q.tail_char;
				fin = 1'b1;
			end
			default: begin
				byte_val = rec_q.run_char;
				fin = 1'b1;
			end
		endcase

		if (emit) begin
			unique case (phase_q)
				PH_DIGIT: begin
					rem_d = rem_next;
					if (pidx_q == '0) begin
						phase_d = PH_CHAR;
					end else begin
						pidx_d = pidx_q - PW'(1);
					end
				end
				PH_CHAR: begin
					if (rec_q.tail_valid) begin
						phase_d = PH_TAIL;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
			if (fin) begin
				cur_valid_d = 1'b0;
			end
		end

		// refill in the cycle the last byte of a record leaves
		load = (!cur_valid_q || (emit && fin)) && !empty;
		if (load) begin
			pop = 1'b1;
			cur_valid_d = 1'b1;
			rec_d = head_rec;
			multi_d = (head_cnt > CW'(1));
			rem_d = head_cnt;
			pidx_d = start_idx;
			phase_d = (head_cnt > CW'(1)) ? PH_DIGIT : PH_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q <= PH_CHAR;
			out_valid_q <= 1'b0;
		end else begin
			cur_valid_q <= cur_valid_d;
			phase_q <= phase_d;
			if (can_load) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= rec_d;
		multi_q <= multi_d;
		rem_q <= rem_d;
		pidx_q <= pidx_d;
		if (emit) begin
			out_char_q <= byte_val;
			out_item_q <= fin;
			out_done_q <= fin && rec_q.done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign out_item = out_item_q;
	assign out_done = out_done_q;

	`CFRLE_ASSERT_IMP(a_done_is_last, out_valid_q && out_done_q, out_item_q,
		"string end on a byte that does not close its transaction")
	`CFRLE_ASSERT_NXT(a_digit_range, emit && phase_q == PH_DIGIT,
		out_char_q >= ASCII_ZERO && out_char_q <= ASCII_ZERO + 8'd9, "digit out of range")
	`CFRLE_ASSERT_IMP(a_tail_present, cur_valid_q && phase_q == PH_TAIL, rec_q.tail_valid,
		"tail phase without a tail character")

endmodule

/* hw/rtl/case_folding_run_length_encoder_top.sv */
// Case-folding run-length encoder: accepts one byte per cycle on the slave stream and
// sends the encoded bytes on the master stream. A run tracker takes a byte every cycle
// while the queue has room and pushes one record per finished run into a four-entry queue;
// the digit emitter drains it at one output byte per cycle unless m_tready stalls it. A
// run yields one byte for a single character, its digits + 1 for a longer run, plus one
// more when the end of the string also flushes a fresh single character. A run of count up
// to 2^COUNT_WIDTH-1 yields at most that number's decimal digit count + 2 bytes. Input is
// stalled only when the queue is full. A run's record goes through the queue and the
// emitter's record register to the output. Depends on cfrle_pkg and the submodules.
module case_folding_run_length_encoder_top #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] char_out
	output logic       m_tuser,   // [0] last_of_item
	output logic       m_tlast    // string_done
);
	import cfrle_pkg::*;

	logic                   push;
	rec_t                   push_rec;
	logic [COUNT_WIDTH-1:0] push_cnt;
	logic                   pop;
	logic                   q_full;
	logic                   q_empty;
	rec_t                   head_rec;
	logic [COUNT_WIDTH-1:0] head_cnt;

	cfrle_front #(.CW(COUNT_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_char  (s_tdata),
		.in_end   (s_tlast),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (push),
		.push_rec (push_rec),
		.push_cnt (push_cnt)
	);

	cfrle_queue #(.CW(COUNT_WIDTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.push_cnt (push_cnt),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head_rec (head_rec),
		.head_cnt (head_cnt)
	);

	cfrle_back #(.CW(COUNT_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head_rec  (head_rec),
		.head_cnt  (head_cnt),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_item  (m_tuser),
		.out_done  (m_tlast)
	);

endmodule

/* tb/tb_case_folding_run_length_encoder_top.sv */
// Self-checking testbench for case_folding_run_length_encoder_top.
// Drives a directed table and then random strings, and checks every encoded byte against
// typed row bytes or an encoder model. Needs only the RTL of the encoder and its package.
`timescale 1ns / 100ps

module tb_case_folding_run_length_encoder_top;

	localparam int COUNT_W = 16;
	localparam int RANDOM_ITEMS = 230;
	localparam int STUCK_LIMIT = 2000;
	localparam int TAIL_CYCLES = 12;

	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7a;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam int UNTYPED = -1;

	// One encoded byte as it leaves the block.
	typedef struct packed {
		logic [7:0] ch;
		logic       last_of_item;
		logic       string_done;
	} enc_byte_t;

	// One directed row: ch is sent reps times, eos applies to the final copy only.
	// typed holds the bytes expected from the final copy, first byte most significant;
	// n_typed of UNTYPED leaves the row to the encoder model.
	typedef struct packed {
		logic [7:0]  ch;
		logic        eos;
		int          reps;
		int          n_typed;
		logic [55:0] typed;
	} stim_row_t;

	localparam int DIR_N = 29;
	localparam stim_row_t DIR_ROWS [DIR_N] = '{
		'{8'h61, 1'b1, 1,     1,       56'h61},            // lone lowercase stays as is
		'{8'h00, 1'b1, 1,     1,       56'h00},            // zero byte is a plain character
		'{8'hff, 1'b1, 1,     1,       56'hff},
		'{8'h78, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h58, 1'b1, 1,     2,       56'("2X")},         // x and X fold into one run
		'{8'h61, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h42, 1'b1, 1,     UNTYPED, 56'h0},
		'{8'h40, 1'b0, 1,     UNTYPED, 56'h0},            // neighbors of the letter ranges
		'{8'h60, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h7b, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h5b, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h7a, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h5a, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h80, 1'b0, 1,     UNTYPED, 56'h0},            // high bytes never fold
		'{8'ha0, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h80, 1'b1, 1,     UNTYPED, 56'h0},
		'{8'h00, 1'b0, 2,     UNTYPED, 56'h0},
		'{8'h00, 1'b1, 1,     2,       56'h3300},          // three zero bytes
		'{8'h6d, 1'b0, 9,     UNTYPED, 56'h0},
		'{8'h4d, 1'b1, 1,     3,       56'("10M")},
		'{8'h71, 1'b0, 5,     UNTYPED, 56'h0},            // mixed-case run of nine
		'{8'h51, 1'b0, 4,     UNTYPED, 56'h0},
		'{8'h7a, 1'b1, 1,     3,       56'("9Qz")},        // close the run and flush a new byte
		'{8'h6b, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h4b, 1'b0, 98,    UNTYPED, 56'h0},
		'{8'h6b, 1'b1, 1,     4,       56'("100K")},
		'{8'h41, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h00, 1'b0, 1,     UNTYPED, 56'h0},
		'{8'h61, 1'b1, 1,     UNTYPED, 56'h0}
	};

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	// encoder model state
	logic [7:0]         run_char;
	logic [COUNT_W-1:0] run_count;
	bit                 run_open;
	enc_byte_t          run_bytes[$];

	enc_byte_t encoded_q[$];
	int        mismatch_cnt;
	int        stuck_cycles;
	bit        tx_burst;
	bit        rx_burst;

	case_folding_run_length_encoder_top #(
		.COUNT_WIDTH(COUNT_W)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] upcase(logic [7:0] c);
		if (c >= LOWER_A && c <= LOWER_Z) begin
			return c - CASE_BIT;
		end
		return c;
	endfunction

	function automatic void push_byte(logic [7:0] c);
		enc_byte_t b;
		b.ch = c;
		b.last_of_item = 1'b0;
		b.string_done = 1'b0;
		run_bytes.push_back(b);
	endfunction

	// Emit the pending run: a lone byte unchanged, else decimal count and folded byte.
	function automatic void close_run();
		int v;
		logic [7:0] digs[$];
		if (run_count <= 1) begin
			push_byte(run_char);
		end else begin
			v = run_count;
			while (v != 0) begin
				digs.push_front(DIGIT_ZERO + 8'(v % 10));
				v = v / 10;
			end
			foreach (digs[i]) begin
				push_byte(digs[i]);
			end
			push_byte(upcase(run_char));
		end
	endfunction

	// Advance the encoder model by one character; leaves its output in run_bytes.
	function automatic void encode_step(logic [7:0] ch, bit eos);
		run_bytes.delete();
		if (run_open && upcase(ch) == upcase(run_char)) begin
			if (run_count != '1) begin
				run_count++;
			end
		end else begin
			if (run_open) begin
				close_run();
			end
			run_char = ch;
			run_count = 1;
			run_open = 1'b1;
		end
		if (eos) begin
			close_run();
			run_char = '0;
			run_count = '0;
			run_open = 1'b0;
		end
		if (run_bytes.size() > 0) begin
			run_bytes[run_bytes.size()-1].last_of_item = 1'b1;
			run_bytes[run_bytes.size()-1].string_done = eos;
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] ERROR: %s", $realtime, what);
		mismatch_cnt++;
	endtask

	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 15);
	endfunction

	// Present one character and hold it until the transaction completes.
	task automatic send_char(input logic [7:0] ch, input bit eos, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= eos;
		do @(posedge clk); while (!s_tready);
	endtask

	// Output side: random stalls, one check per transaction.
	initial begin
		enc_byte_t want;
		int stall;
		m_tready = 1'b0;
		rx_burst = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 31) == 0) begin
				rx_burst = !rx_burst;
			end
			stall = draw_gap(rx_burst);
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (encoded_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", m_tdata));
			end else begin
				want = encoded_q.pop_front();
				if (m_tdata !== want.ch) begin
					report_mismatch($sformatf("char_out %02h, want %02h", m_tdata, want.ch));
				end
				if (m_tuser !== want.last_of_item) begin
					report_mismatch($sformatf("last_of_item %b, want %b", m_tuser,
						want.last_of_item));
				end
				if (m_tlast !== want.string_done) begin
					report_mismatch($sformatf("string_done %b, want %b", m_tlast,
						want.string_done));
				end
			end
		end
	end

	// End the run when no transaction happens for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t row;
		enc_byte_t b;
		bit eos;
		bit final_copy;
		int gap;
		int items_sent;
		int n_runs;
		int run_len;
		int sel;
		logic [7:0] base;
		logic [7:0] ch;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		run_char = '0;
		run_count = '0;
		run_open = 1'b0;
		mismatch_cnt = 0;
		tx_burst = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIR_ROWS[k]) begin
			row = DIR_ROWS[k];
			for (int r = 0; r < row.reps; r++) begin
				final_copy = (r == row.reps - 1);
				eos = row.eos && final_copy;
				gap = draw_gap(tx_burst);
				send_char(row.ch, eos, gap);
				encode_step(row.ch, eos);
				if (final_copy && row.n_typed != UNTYPED) begin
					for (int i = 0; i < row.n_typed; i++) begin
						b.ch = row.typed[8*(row.n_typed-1-i) +: 8];
						b.last_of_item = (i == row.n_typed - 1);
						b.string_done = (i == row.n_typed - 1) && eos;
						encoded_q.push_back(b);
					end
				end else begin
					foreach (run_bytes[i]) encoded_q.push_back(run_bytes[i]);
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				tx_burst = !tx_burst;
			end
		end

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			n_runs = $urandom_range(1, 6);
			for (int rn = 0; rn < n_runs; rn++) begin
				sel = $urandom_range(0, 3);
				case (sel)
					0: base = 8'($urandom_range(0, 255));
					1, 2: base = LOWER_A + 8'($urandom_range(0, 25));
					default: base = 8'h40 + 8'($urandom_range(0, 63));
				endcase
				sel = $urandom_range(0, 19);
				if (sel < 12) begin
					run_len = $urandom_range(1, 3);
				end else if (sel < 19) begin
					run_len = $urandom_range(4, 12);
				end else begin
					run_len = $urandom_range(13, 110);
				end
				for (int c = 0; c < run_len; c++) begin
					ch = base;
					// flip case at random inside letter runs
					if (upcase(base) != base && $urandom_range(0, 1) == 1) begin
						ch = base ^ CASE_BIT;
					end
					eos = (rn == n_runs - 1) && (c == run_len - 1);
					send_char(ch, eos, draw_gap(tx_burst));
					encode_step(ch, eos);
					foreach (run_bytes[i]) encoded_q.push_back(run_bytes[i]);
					items_sent++;
				end
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (encoded_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
